/* hdl/btm_pkg.sv */
// Shared types, codes and field layout of the bus transaction timing monitor.
`default_nettype none
package btm_pkg;
	localparam int NUM_CLIENTS  = 3;
	localparam int CNT_W        = 32;
	localparam int TIME_W       = 32;
	localparam int CLIENT_W     = 2;
	localparam int FUNC_W       = 2;
	localparam int SEL_W        = 5;
	localparam int DIV_CNT_W    = $clog2(TIME_W + 1);
	localparam int IN_BITS      = FUNC_W + CLIENT_W + 5 * TIME_W + SEL_W;
	localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W        = ((TIME_W + 1 + 7) / 8) * 8;
	localparam logic [TIME_W-1:0] US_PER_MS = TIME_W'(1000);

	// fixed-point reciprocal of 1000: floor(x / 1000) = (x * MS_RECIP) >> MS_SHIFT
	// holds for every 32-bit x
	localparam int MS_RECIP_W = 29;
	localparam int MS_SHIFT   = 38;
	localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;

	// event codes
	localparam logic [FUNC_W-1:0] FN_XFER     = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEADLINE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ     = 2'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR    = 2'd3;

	// clients
	localparam logic [CLIENT_W-1:0] CL_ADC      = 2'd0;
	localparam logic [CLIENT_W-1:0] CL_INERTIAL = 2'd1;
	localparam logic [CLIENT_W-1:0] CL_ACTUATOR = 2'd2;
	localparam logic [CLIENT_W-1:0] NO_CLIENT   = CLIENT_W'(NUM_CLIENTS);

	// switch classes
	localparam logic [1:0] DIR_ADC_INR = 2'd0;
	localparam logic [1:0] DIR_INR_ADC = 2'd1;
	localparam logic [1:0] DIR_OTHER   = 2'd2;

	// telemetry word selectors
	localparam logic [SEL_W-1:0] SEL_WINDOW       = 5'd0;
	localparam logic [SEL_W-1:0] SEL_BUSY         = 5'd1;
	localparam logic [SEL_W-1:0] SEL_BUS_XFERS    = 5'd2;
	localparam logic [SEL_W-1:0] SEL_INR_XFERS    = 5'd3;
	localparam logic [SEL_W-1:0] SEL_ADC_XFERS    = 5'd4;
	localparam logic [SEL_W-1:0] SEL_ACT_XFERS    = 5'd5;
	localparam logic [SEL_W-1:0] SEL_INR_LAT      = 5'd6;
	localparam logic [SEL_W-1:0] SEL_INR_LAT_MAX  = 5'd7;
	localparam logic [SEL_W-1:0] SEL_ADC_LAT      = 5'd8;
	localparam logic [SEL_W-1:0] SEL_ADC_LAT_MAX  = 5'd9;
	localparam logic [SEL_W-1:0] SEL_ACT_LAT      = 5'd10;
	localparam logic [SEL_W-1:0] SEL_ACT_LAT_MAX  = 5'd11;
	localparam logic [SEL_W-1:0] SEL_SW_TOTAL     = 5'd12;
	localparam logic [SEL_W-1:0] SEL_SW_AI        = 5'd13;
	localparam logic [SEL_W-1:0] SEL_SW_IA        = 5'd14;
	localparam logic [SEL_W-1:0] SEL_SW_OTHER     = 5'd15;
	localparam logic [SEL_W-1:0] SEL_GAP_AI       = 5'd16;
	localparam logic [SEL_W-1:0] SEL_GAP_AI_MAX   = 5'd17;
	localparam logic [SEL_W-1:0] SEL_GAP_IA       = 5'd18;
	localparam logic [SEL_W-1:0] SEL_GAP_IA_MAX   = 5'd19;
	localparam logic [SEL_W-1:0] SEL_SSW_AI       = 5'd20;
	localparam logic [SEL_W-1:0] SEL_SSW_IA       = 5'd21;
	localparam logic [SEL_W-1:0] SEL_SGAP_AI      = 5'd22;
	localparam logic [SEL_W-1:0] SEL_SGAP_AI_MAX  = 5'd23;
	localparam logic [SEL_W-1:0] SEL_SGAP_IA      = 5'd24;
	localparam logic [SEL_W-1:0] SEL_SGAP_IA_MAX  = 5'd25;
	localparam logic [SEL_W-1:0] SEL_INR_MISSES   = 5'd26;
	localparam logic [SEL_W-1:0] SEL_ADC_MISSES   = 5'd27;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
		logic push;
	} btm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic need_mul;
		logic div_done;
	} btm_status_t;
endpackage
`default_nettype wire

/* hdl/bus_transaction_timing_monitor.sv */
// Top level of the bus transaction timing monitor.
//
//   channel | direction | payload
//   s_axis  | in        | event: func, client, times, poll_period, counter_sel
//   m_axis  | out       | result: read_value, deadline_missed
//
// One event at a time. Transfer, plain read, clear and deadline events without
// catch-up go from the execute state straight to the output state; the
// window-length read passes a finish state to scale by a fixed-point reciprocal
// of 1000. Deadline catch-up waits on a restoring divider that resolves one
// quotient bit per cycle. The next event is accepted once the result is pushed.
// arst_n clears all counters and times; a result waiting in the output
// register does not block the next event from being accepted.
`default_nettype none
module bus_transaction_timing_monitor (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// func, client, request_time, lock_time, end_time, now_time,
	// poll_period, counter_sel, zero pad
	input  wire [btm_pkg::IN_W-1:0]     s_tdata,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	// read_value, deadline_missed, zero pad
	output logic [btm_pkg::OUT_W-1:0]   m_tdata
);
	import btm_pkg::*;

	btm_cmd_t    cmd;
	btm_status_t status;

	btm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	btm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_tdata)
	);
endmodule
`default_nettype wire

/* hdl/btm_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module btm_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [btm_pkg::TIME_W-1:0]    dividend,
	input  wire [btm_pkg::TIME_W-1:0]    divisor,
	output logic                         done,
	output logic [btm_pkg::TIME_W-1:0]   remainder
);
	import btm_pkg::*;

	logic [TIME_W-1:0]    num_q;
	logic [TIME_W-1:0]    den_q;
	logic [TIME_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_W:0]      trial;
	logic                 fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, num_q[TIME_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath of the iteration
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[TIME_W-2:0], fits};
			rem_q <= fits ? TIME_W'(trial - {1'b0, den_q}) : trial[TIME_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

/* hdl/btm_dp.sv */
// Datapath: event registers, telemetry state, divider and result registers.
`default_nettype none
module btm_dp (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire [btm_pkg::IN_W-1:0]       in_data,
	input  btm_pkg::btm_cmd_t             cmd,
	output btm_pkg::btm_status_t          status,
	output logic [btm_pkg::OUT_W-1:0]     out_data
);
	import btm_pkg::*;

	// latched event
	logic [FUNC_W-1:0]   func_q;
	logic [CLIENT_W-1:0] client_q;
	logic [TIME_W-1:0]   req_q, lock_q, end_q, now_q, period_q;
	logic [SEL_W-1:0]    sel_q;

	// telemetry state
	logic [TIME_W-1:0] next_due_q   [NUM_CLIENTS];
	logic [CNT_W-1:0]  misses_q     [NUM_CLIENTS];
	logic [CNT_W-1:0]  xfers_q      [NUM_CLIENTS];
	logic [TIME_W-1:0] lat_last_q   [NUM_CLIENTS];
	logic [TIME_W-1:0] lat_max_q    [NUM_CLIENTS];
	logic [CNT_W-1:0]  busy_q;
	logic [CNT_W-1:0]  bus_xfers_q;
	logic [TIME_W-1:0] win_start_q;
	logic [CLIENT_W-1:0] prev_client_q;
	logic [TIME_W-1:0] prev_end_q;
	logic [CNT_W-1:0]  sw_total_q;
	logic [CNT_W-1:0]  sw_class_q   [3];
	logic [TIME_W-1:0] gap_last_q   [2];
	logic [TIME_W-1:0] gap_max_q    [2];
	logic [CLIENT_W-1:0] prev_sens_q;
	logic [TIME_W-1:0] prev_sens_end_q;
	logic [CNT_W-1:0]  ssw_q        [2];
	logic [TIME_W-1:0] sgap_last_q  [2];
	logic [TIME_W-1:0] sgap_max_q   [2];

	// results
	logic [TIME_W-1:0] res_value_q;
	logic              res_missed_q;
	logic [TIME_W-1:0] out_value_q;
	logic              out_missed_q;

	logic              client_ok, is_sensor, do_switch, do_sens_switch;
	logic [TIME_W-1:0] latency, gap, sgap, due, due_plus;
	logic [1:0]        dir;
	logic              need_div, need_mul, in_window, div_done;
	logic [TIME_W-1:0] win_span, remainder;
	logic [TIME_W+MS_RECIP_W-1:0] ms_prod;
	logic [TIME_W-1:0] read_word;

	// transfer and deadline terms
	assign client_ok      = client_q < NO_CLIENT;
	assign latency        = end_q - req_q;
	assign is_sensor      = (client_q == CL_ADC) || (client_q == CL_INERTIAL);
	assign do_switch      = (prev_client_q != NO_CLIENT) && (prev_client_q != client_q);
	assign do_sens_switch = is_sensor && (prev_sens_q != NO_CLIENT) &&
		(prev_sens_q != client_q);
	assign gap            = (prev_end_q == '0) ? '0 : lock_q - prev_end_q;
	assign sgap           = (prev_sens_end_q == '0) ? '0 : lock_q - prev_sens_end_q;
	assign due            = client_ok ? next_due_q[client_q] : '0;
	assign due_plus       = due + period_q;

	always_comb begin
		if (prev_client_q == CL_ADC && client_q == CL_INERTIAL) begin
			dir = DIR_ADC_INR;
		end else if (prev_client_q == CL_INERTIAL && client_q == CL_ADC) begin
			dir = DIR_INR_ADC;
		end else begin
			dir = DIR_OTHER;
		end
	end

	// deadline catch-up needs the divider
	assign need_div = (func_q == FN_DEADLINE) && client_ok && (period_q != '0) &&
		(due != '0) && (due <= now_q);

	// window length: elapsed time now, scaled to milliseconds in the finish cycle
	assign in_window = (win_start_q != '0) && (now_q > win_start_q);
	assign win_span  = in_window ? now_q - win_start_q : '0;
	assign need_mul  = (func_q == FN_READ) && (sel_q == SEL_WINDOW) && in_window;
	assign ms_prod   = res_value_q * MS_RECIP;

	btm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.exec && need_div),
		.dividend  (now_q - due),
		.divisor   (period_q),
		.done      (div_done),
		.remainder (remainder)
	);

	assign status.need_div = need_div;
	assign status.need_mul = need_mul;
	assign status.div_done = div_done;

	// telemetry word select
	always_comb begin
		unique case (sel_q)
			SEL_WINDOW:      read_word = win_span;
			SEL_BUSY:        read_word = busy_q;
			SEL_BUS_XFERS:   read_word = bus_xfers_q;
			SEL_INR_XFERS:   read_word = xfers_q[CL_INERTIAL];
			SEL_ADC_XFERS:   read_word = xfers_q[CL_ADC];
			SEL_ACT_XFERS:   read_word = xfers_q[CL_ACTUATOR];
			SEL_INR_LAT:     read_word = lat_last_q[CL_INERTIAL];
			SEL_INR_LAT_MAX: read_word = lat_max_q[CL_INERTIAL];
			SEL_ADC_LAT:     read_word = lat_last_q[CL_ADC];
			SEL_ADC_LAT_MAX: read_word = lat_max_q[CL_ADC];
			SEL_ACT_LAT:     read_word = lat_last_q[CL_ACTUATOR];
			SEL_ACT_LAT_MAX: read_word = lat_max_q[CL_ACTUATOR];
			SEL_SW_TOTAL:    read_word = sw_total_q;
			SEL_SW_AI:       read_word = sw_class_q[DIR_ADC_INR];
			SEL_SW_IA:       read_word = sw_class_q[DIR_INR_ADC];
			SEL_SW_OTHER:    read_word = sw_class_q[DIR_OTHER];
			SEL_GAP_AI:      read_word = gap_last_q[0];
			SEL_GAP_AI_MAX:  read_word = gap_max_q[0];
			SEL_GAP_IA:      read_word = gap_last_q[1];
			SEL_GAP_IA_MAX:  read_word = gap_max_q[1];
			SEL_SSW_AI:      read_word = ssw_q[0];
			SEL_SSW_IA:      read_word = ssw_q[1];
			SEL_SGAP_AI:     read_word = sgap_last_q[0];
			SEL_SGAP_AI_MAX: read_word = sgap_max_q[0];
			SEL_SGAP_IA:     read_word = sgap_last_q[1];
			SEL_SGAP_IA_MAX: read_word = sgap_max_q[1];
			SEL_INR_MISSES:  read_word = misses_q[CL_INERTIAL];
			SEL_ADC_MISSES:  read_word = misses_q[CL_ADC];
			default:         read_word = '0;
		endcase
	end

	// capture the accepted event
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_data[1:0];
			client_q <= in_data[3:2];
			req_q    <= in_data[35:4];
			lock_q   <= in_data[67:36];
			end_q    <= in_data[99:68];
			now_q    <= in_data[131:100];
			period_q <= in_data[163:132];
			sel_q    <= in_data[168:164];
		end
	end

	// apply the event to the telemetry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLIENTS; i++) begin
				next_due_q[i] <= '0;
				misses_q[i]   <= '0;
				xfers_q[i]    <= '0;
				lat_last_q[i] <= '0;
				lat_max_q[i]  <= '0;
			end
			for (int i = 0; i < 3; i++) sw_class_q[i] <= '0;
			for (int i = 0; i < 2; i++) begin
				gap_last_q[i]  <= '0;
				gap_max_q[i]   <= '0;
				ssw_q[i]       <= '0;
				sgap_last_q[i] <= '0;
				sgap_max_q[i]  <= '0;
			end
			busy_q          <= '0;
			bus_xfers_q     <= '0;
			win_start_q     <= '0;
			prev_client_q   <= NO_CLIENT;
			prev_end_q      <= '0;
			sw_total_q      <= '0;
			prev_sens_q     <= NO_CLIENT;
			prev_sens_end_q <= '0;
			res_value_q     <= '0;
			res_missed_q    <= 1'b0;
		end else if (cmd.exec) begin
			res_value_q  <= (func_q == FN_READ) ? read_word : '0;
			res_missed_q <= 1'b0;
			unique case (func_q)
				FN_XFER: begin
					if (client_ok) begin
						xfers_q[client_q]    <= xfers_q[client_q] + 1'b1;
						lat_last_q[client_q] <= latency;
						if (latency > lat_max_q[client_q]) lat_max_q[client_q] <= latency;
						busy_q      <= busy_q + latency;
						bus_xfers_q <= bus_xfers_q + 1'b1;
						if (do_switch) begin
							sw_total_q      <= sw_total_q + 1'b1;
							sw_class_q[dir] <= sw_class_q[dir] + 1'b1;
							if (dir != DIR_OTHER) begin
								gap_last_q[dir[0]] <= gap;
								if (gap > gap_max_q[dir[0]]) gap_max_q[dir[0]] <= gap;
							end
						end
						prev_client_q <= client_q;
						prev_end_q    <= end_q;
						if (is_sensor) begin
							if (do_sens_switch) begin
								ssw_q[client_q[0] ^ 1'b1 ? 1'b1 : 1'b0] <=
									ssw_q[~client_q[0]] + 1'b1;
								sgap_last_q[~client_q[0]] <= sgap;
								if (sgap > sgap_max_q[~client_q[0]]) begin
									sgap_max_q[~client_q[0]] <= sgap;
								end
							end
							prev_sens_q     <= client_q;
							prev_sens_end_q <= end_q;
						end
					end
				end
				FN_DEADLINE: begin
					if (client_ok && period_q != '0) begin
						if (due == '0) begin
							next_due_q[client_q] <= now_q + period_q;
						end else if (now_q > due_plus) begin
							misses_q[client_q] <= misses_q[client_q] + 1'b1;
							res_missed_q       <= 1'b1;
						end
					end
				end
				FN_READ: begin
				end
				FN_CLEAR: begin
					for (int i = 0; i < NUM_CLIENTS; i++) begin
						next_due_q[i] <= '0;
						misses_q[i]   <= '0;
						xfers_q[i]    <= '0;
						lat_last_q[i] <= '0;
						lat_max_q[i]  <= '0;
					end
					for (int i = 0; i < 3; i++) sw_class_q[i] <= '0;
					for (int i = 0; i < 2; i++) begin
						gap_last_q[i]  <= '0;
						gap_max_q[i]   <= '0;
						ssw_q[i]       <= '0;
						sgap_last_q[i] <= '0;
						sgap_max_q[i]  <= '0;
					end
					busy_q          <= '0;
					bus_xfers_q     <= '0;
					win_start_q     <= now_q;
					prev_client_q   <= NO_CLIENT;
					prev_end_q      <= '0;
					sw_total_q      <= '0;
					prev_sens_q     <= NO_CLIENT;
					prev_sens_end_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.finish) begin
			// catch-up lands on now - ((now - due) mod period) + period
			if (func_q == FN_DEADLINE) begin
				next_due_q[client_q] <= now_q - remainder + period_q;
			end else begin
				res_value_q <= TIME_W'(ms_prod >> MS_SHIFT);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_value_q  <= res_value_q;
			out_missed_q <= res_missed_q;
		end
	end

	assign out_data = {{(OUT_W - TIME_W - 1){1'b0}}, out_missed_q, out_value_q};
endmodule
`default_nettype wire

/* hdl/btm_ctrl.sv */
// Controller: sequences accept, execute, divide, finish and result transfer.
`default_nettype none
module btm_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire                     out_ready,
	output btm_pkg::btm_cmd_t       cmd,
	input  btm_pkg::btm_status_t    status
);
	import btm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;

	assign cmd.load   = in_valid && in_ready;
	assign cmd.exec   = (state_q == S_EXEC);
	assign cmd.finish = (state_q == S_FIN);
	assign cmd.push   = (state_q == S_OUT) && slot_free;

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (status.need_div) begin
						state_q <= S_WAIT;
					end else if (status.need_mul) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_WAIT: if (status.div_done) state_q <= S_FIN;
				S_FIN:  state_q <= S_OUT;
				S_OUT:  if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* bench/btm_checker.sv */
// Result predictor and scoreboard for the bus transaction timing monitor.
module btm_checker import btm_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	input  wire                 s_tready,
	input  wire [IN_W-1:0]      s_tdata,
	input  wire                 m_tvalid,
	input  wire                 m_tready,
	input  wire [OUT_W-1:0]     m_tdata,
	output int                  outstanding,
	output int                  errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] value;
		logic        missed;
	} outcome_t;

	logic [31:0] due_at [NUM_CLIENTS];
	logic [31:0] misses [NUM_CLIENTS];
	logic [31:0] xfers [NUM_CLIENTS];
	logic [31:0] lat_last [NUM_CLIENTS];
	logic [31:0] lat_max [NUM_CLIENTS];
	logic [31:0] busy, bus_xfers, win_start, last_end, sw_total, sens_end;
	logic [1:0]  last_cl, sens_cl;
	logic [31:0] sw_class [3];
	logic [31:0] gap_last [2];
	logic [31:0] gap_max [2];
	logic [31:0] ssw [2];
	logic [31:0] sgap_last [2];
	logic [31:0] sgap_max [2];
	outcome_t    pending_q [$];

	// clear every counter, as reset and the clear event do
	task automatic wipe_state();
		for (int i = 0; i < NUM_CLIENTS; i++) begin
			due_at[i] = 0; misses[i] = 0; xfers[i] = 0; lat_last[i] = 0; lat_max[i] = 0;
		end
		for (int i = 0; i < 3; i++) sw_class[i] = 0;
		for (int i = 0; i < 2; i++) begin
			gap_last[i] = 0; gap_max[i] = 0; ssw[i] = 0; sgap_last[i] = 0; sgap_max[i] = 0;
		end
		busy = 0; bus_xfers = 0; win_start = 0; last_end = 0; sw_total = 0; sens_end = 0;
		last_cl = NO_CLIENT; sens_cl = NO_CLIENT;
	endtask

	function automatic logic [1:0] switch_class(logic [1:0] from, logic [1:0] to);
		if (from == CL_ADC && to == CL_INERTIAL) return DIR_ADC_INR;
		if (from == CL_INERTIAL && to == CL_ADC) return DIR_INR_ADC;
		return DIR_OTHER;
	endfunction

	task automatic log_transfer(logic [1:0] c, logic [31:0] req, logic [31:0] lock,
			logic [31:0] fin);
		logic [31:0] lat, gap;
		logic [1:0]  d;
		lat = fin - req;
		xfers[c]++;
		lat_last[c] = lat;
		if (lat > lat_max[c]) lat_max[c] = lat;
		busy += lat;
		bus_xfers++;
		// any client change
		if (last_cl != NO_CLIENT && last_cl != c) begin
			gap = (last_end == 0) ? 32'd0 : lock - last_end;
			d = switch_class(last_cl, c);
			sw_total++;
			sw_class[d]++;
			if (d != DIR_OTHER) begin
				gap_last[d] = gap;
				if (gap > gap_max[d]) gap_max[d] = gap;
			end
		end
		last_cl = c;
		last_end = fin;
		// sensor-only record
		if (c == CL_ADC || c == CL_INERTIAL) begin
			if (sens_cl != NO_CLIENT && sens_cl != c) begin
				gap = (sens_end == 0) ? 32'd0 : lock - sens_end;
				d = switch_class(sens_cl, c);
				if (d != DIR_OTHER) begin
					ssw[d]++;
					sgap_last[d] = gap;
					if (gap > sgap_max[d]) sgap_max[d] = gap;
				end
			end
			sens_cl = c;
			sens_end = fin;
		end
	endtask

	function automatic logic [31:0] telemetry(logic [SEL_W-1:0] sel, logic [31:0] now);
		case (sel)
			SEL_WINDOW:      return (win_start == 0 || now <= win_start) ? 32'd0 :
				(now - win_start) / US_PER_MS;
			SEL_BUSY:        return busy;
			SEL_BUS_XFERS:   return bus_xfers;
			SEL_INR_XFERS:   return xfers[CL_INERTIAL];
			SEL_ADC_XFERS:   return xfers[CL_ADC];
			SEL_ACT_XFERS:   return xfers[CL_ACTUATOR];
			SEL_INR_LAT:     return lat_last[CL_INERTIAL];
			SEL_INR_LAT_MAX: return lat_max[CL_INERTIAL];
			SEL_ADC_LAT:     return lat_last[CL_ADC];
			SEL_ADC_LAT_MAX: return lat_max[CL_ADC];
			SEL_ACT_LAT:     return lat_last[CL_ACTUATOR];
			SEL_ACT_LAT_MAX: return lat_max[CL_ACTUATOR];
			SEL_SW_TOTAL:    return sw_total;
			SEL_SW_AI:       return sw_class[DIR_ADC_INR];
			SEL_SW_IA:       return sw_class[DIR_INR_ADC];
			SEL_SW_OTHER:    return sw_class[DIR_OTHER];
			SEL_GAP_AI:      return gap_last[DIR_ADC_INR];
			SEL_GAP_AI_MAX:  return gap_max[DIR_ADC_INR];
			SEL_GAP_IA:      return gap_last[DIR_INR_ADC];
			SEL_GAP_IA_MAX:  return gap_max[DIR_INR_ADC];
			SEL_SSW_AI:      return ssw[DIR_ADC_INR];
			SEL_SSW_IA:      return ssw[DIR_INR_ADC];
			SEL_SGAP_AI:     return sgap_last[DIR_ADC_INR];
			SEL_SGAP_AI_MAX: return sgap_max[DIR_ADC_INR];
			SEL_SGAP_IA:     return sgap_last[DIR_INR_ADC];
			SEL_SGAP_IA_MAX: return sgap_max[DIR_INR_ADC];
			SEL_INR_MISSES:  return misses[CL_INERTIAL];
			SEL_ADC_MISSES:  return misses[CL_ADC];
			default:         return 32'd0;
		endcase
	endfunction

	// advance the state by one event and return what it yields
	task automatic apply_event(logic [IN_W-1:0] d, output outcome_t res);
		logic [1:0]       fn, c;
		logic [31:0]      req, lock, fin, now, per;
		logic [SEL_W-1:0] sel;
		logic [63:0]      k;
		{sel, per, now, fin, lock, req, c, fn} = d[IN_BITS-1:0];
		res = '0;
		case (fn)
			FN_XFER: if (c != NO_CLIENT) log_transfer(c, req, lock, fin);
			FN_DEADLINE: if (c != NO_CLIENT && per != 0) begin
				if (due_at[c] == 0) begin
					due_at[c] = now + per;
				end else begin
					if (now > due_at[c] + per) begin
						misses[c]++;
						res.missed = 1'b1;
					end
					if (due_at[c] <= now) begin
						k = 64'(now - due_at[c]) / 64'(per) + 64'd1;
						due_at[c] = 32'(64'(due_at[c]) + k * 64'(per));
					end
				end
			end
			FN_READ: res.value = telemetry(sel, now);
			default: begin
				wipe_state();
				win_start = now;
			end
		endcase
	endtask

	assign outstanding = pending_q.size();

	// compare the result first, then log the new event
	always @(posedge clk or negedge arst_n) begin
		outcome_t want, fresh;
		if (!arst_n) begin
			wipe_state();
			pending_q.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					$error("result transfer with nothing pending: %h", m_tdata);
					errors = errors + 1;
				end else begin
					want = pending_q.pop_front();
					if (m_tdata[31:0] !== want.value) begin
						$error("read_value expected %h actual %h", want.value, m_tdata[31:0]);
						errors = errors + 1;
					end
					if (m_tdata[32] !== want.missed) begin
						$error("deadline_missed expected %b actual %b", want.missed, m_tdata[32]);
						errors = errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_event(s_tdata, fresh);
				pending_q.push_back(fresh);
			end
		end
	end
endmodule

/* bench/bus_transaction_timing_monitor_tb.sv */
// Stimulus and verdict for the bus transaction timing monitor.
module bus_transaction_timing_monitor_tb;
	import btm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	int               outstanding, errors;
	int               idle_pct = 0, stall_pct = 0, hold_cycles = 0;
	logic [31:0]      now_us = 32'd5000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bus_transaction_timing_monitor dut (.*);
	btm_checker chk (.*);

	// receiver: long hold-off or random stall
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(logic [1:0] fn, logic [1:0] c, logic [31:0] req, logic [31:0] lock,
			logic [31:0] fin, logic [31:0] now, logic [31:0] per, logic [SEL_W-1:0] sel);
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({sel, per, now, fin, lock, req, c, fn});
		do @(posedge clk); while (!s_tready);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// mostly coherent timelines, some fully random fields
	task automatic random_event();
		logic [1:0]  fn, c;
		logic [31:0] req, lock, fin, per;
		int          r;
		r = $urandom_range(99);
		fn = (r < 45) ? FN_XFER : (r < 70) ? FN_DEADLINE : (r < 96) ? FN_READ : FN_CLEAR;
		c = ($urandom_range(19) == 0) ? NO_CLIENT : 2'($urandom_range(2));
		now_us += $urandom_range(1, 3000);
		if ($urandom_range(9) == 0) begin
			send(fn, 2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
				SEL_W'($urandom));
		end else begin
			req = now_us;
			lock = req + $urandom_range(0, 200);
			fin = lock + $urandom_range(0, 500);
			per = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 4000);
			send(fn, c, req, lock, fin, now_us, per, SEL_W'($urandom_range(31)));
			now_us = fin;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: window edges, switches, deadline corners, unused selectors
		send(FN_READ, CL_ADC, 0, 0, 0, 32'd1234567, 0, SEL_WINDOW);
		send(FN_XFER, CL_ADC, 32'd10, 32'd20, 32'd0, 0, 0, 0);
		send(FN_XFER, CL_INERTIAL, 32'd30, 32'd40, 32'd90, 0, 0, 0);
		send(FN_XFER, CL_ADC, 32'd100, 32'd95, 32'd150, 0, 0, 0);
		send(FN_XFER, CL_ACTUATOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 0, 0, 0);
		send(FN_XFER, CL_INERTIAL, 32'd200, 32'd210, 32'd260, 0, 0, 0);
		send(FN_XFER, NO_CLIENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		send(FN_DEADLINE, CL_ADC, 0, 0, 0, 32'd100, 32'd0, 0);
		send(FN_DEADLINE, CL_ADC, 0, 0, 0, 32'd100, 32'd50, 0);
		send(FN_DEADLINE, CL_ADC, 0, 0, 0, 32'd400, 32'd50, 0);
		send(FN_DEADLINE, CL_INERTIAL, 0, 0, 0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0);
		send(FN_DEADLINE, CL_INERTIAL, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0);
		send(FN_DEADLINE, NO_CLIENT, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		for (int s = 0; s < 32; s += 3) send(FN_READ, CL_ADC, 0, 0, 0, 32'd77, 0, SEL_W'(s));
		send(FN_READ, NO_CLIENT, 0, 0, 0, 0, 0, 5'd31);
		send(FN_CLEAR, CL_ACTUATOR, 0, 0, 0, 32'd1000, 0, 0);
		send(FN_READ, CL_ADC, 0, 0, 0, 32'hFFFF_FFFF, 0, SEL_WINDOW);
		send(FN_READ, CL_ADC, 0, 0, 0, 32'd999, 0, SEL_WINDOW);
		// random phases under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 74 : (ph == 3) ? 14 : 0;
			stall_pct = (ph == 2) ? 74 : (ph == 3) ? 14 : 0;
			for (int i = 0; i < 420; i++) begin
				if (ph == 2 && i == 100) hold_cycles = 300;
				random_event();
			end
			// pause until every result has come back
			s_tvalid <= 1'b0;
			while (outstanding != 0) @(posedge clk);
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		stall_pct = 0;
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
